/* src/hmps_pkg.sv */
// ----------------------------------------------------------------------------
// Height map placement scorer package
// Shared constants, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package hmps_pkg;

  localparam int MAP_X       = 32;
  localparam int MAP_Y       = 32;
  localparam int HEIGHT_BITS = 8;

  localparam int MAP_CELLS = MAP_X * MAP_Y;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int X_W       = $clog2(MAP_X);
  localparam int Y_W       = $clog2(MAP_Y);

  localparam int COORD_FW = 5;
  localparam int LEN_FW   = 6;
  localparam int CELL_FW  = 8;
  localparam int BOX_Z_W  = 8;
  localparam int TOL_W    = 8;
  localparam int SUM_W    = 17;
  localparam int CNT_W    = 8;

  localparam int SIDE_MARGIN = 2;
  localparam int COORD_W     = 10;
  localparam int EXT_W       = (HEIGHT_BITS > BOX_Z_W) ? HEIGHT_BITS : BOX_Z_W;
  localparam int MIS_W       = EXT_W + 1;
  localparam int DIFF_W      = EXT_W + 2;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    SIDE_LOW_X  = 2'd0,
    SIDE_LOW_Y  = 2'd1,
    SIDE_HIGH_X = 2'd2,
    SIDE_HIGH_Y = 2'd3
  } side_e;

  typedef struct packed {
    logic [COORD_FW-1:0] coord_x;
    logic [COORD_FW-1:0] coord_y;
    logic [CELL_FW-1:0]  cell_height;
    logic [LEN_FW-1:0]   box_x_len;
    logic [LEN_FW-1:0]   box_y_len;
    logic [BOX_Z_W-1:0]  box_z_len;
  } item_t;

  typedef struct packed {
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              start;
    logic              write;
    logic              issue;
    side_e             side;
    logic [LEN_FW-1:0] idx;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic [LEN_FW-1:0] cur_len;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/hmps_ctrl.sv */
// ----------------------------------------------------------------------------
// Height map placement scorer controller
// Sequences the reset clearing sweep, input acceptance, the side walk and the result load.
// ----------------------------------------------------------------------------
`default_nettype none

module hmps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_mode_i,
  output logic               in_ready_o,
  input  wire hmps_pkg::sts_t sts_i,
  output hmps_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  hmps_pkg::side_e                 side_q, side_d;
  logic [hmps_pkg::LEN_FW-1:0]     idx_q, idx_d;
  logic [hmps_pkg::ADDR_W-1:0]     clr_addr_q, clr_addr_d;
  logic                            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    side_d     = side_q;
    idx_d      = idx_q;
    clr_addr_d = clr_addr_q;

    cmd_o          = '0;
    cmd_o.clr_addr = clr_addr_q;
    cmd_o.side     = side_q;
    cmd_o.idx      = idx_q;

    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_addr_d   = clr_addr_q + hmps_pkg::ADDR_W'(1);
        if (clr_addr_q == hmps_pkg::ADDR_W'(hmps_pkg::MAP_CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode_i) begin
            cmd_o.start = 1'b1;
            side_d      = hmps_pkg::SIDE_LOW_X;
            idx_d       = '0;
            state_d     = ST_RUN;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (idx_q < sts_i.cur_len) begin
          cmd_o.issue = 1'b1;
          idx_d       = idx_q + hmps_pkg::LEN_FW'(1);
        end else if (side_q == hmps_pkg::SIDE_HIGH_Y) begin
          state_d = ST_DRAIN;
        end else begin
          side_d = hmps_pkg::side_e'(side_q + 2'd1);
          idx_d  = '0;
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      side_q     <= hmps_pkg::SIDE_LOW_X;
      idx_q      <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      side_q     <= side_d;
      idx_q      <= idx_d;
      clr_addr_q <= clr_addr_d;
    end
  end

endmodule

`default_nettype wire

/* src/hmps_datapath.sv */
// ----------------------------------------------------------------------------
// Height map placement scorer datapath
// Height map memory, side address generation, mismatch accumulation and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmps_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire hmps_pkg::item_t                 item_i,
  input  wire hmps_pkg::cmd_t                  cmd_i,
  output hmps_pkg::sts_t                       sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [hmps_pkg::TOL_W-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [hmps_pkg::SUM_W-1:0]           out_sum_o,
  output logic [hmps_pkg::CNT_W-1:0]           out_flush_o,
  output logic [hmps_pkg::CNT_W-1:0]           out_high_o
);

  typedef logic signed [hmps_pkg::DIFF_W-1:0] diff_t;

  function automatic logic [hmps_pkg::X_W-1:0] clamp_x(hmps_pkg::coord_t v);
    logic [hmps_pkg::X_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hmps_pkg::coord_t'(hmps_pkg::MAP_X - 1)) begin
      r = hmps_pkg::X_W'(hmps_pkg::MAP_X - 1);
    end else begin
      r = v[hmps_pkg::X_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [hmps_pkg::Y_W-1:0] clamp_y(hmps_pkg::coord_t v);
    logic [hmps_pkg::Y_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > hmps_pkg::coord_t'(hmps_pkg::MAP_Y - 1)) begin
      r = hmps_pkg::Y_W'(hmps_pkg::MAP_Y - 1);
    end else begin
      r = v[hmps_pkg::Y_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [hmps_pkg::ADDR_W-1:0] cell_addr(
    logic [hmps_pkg::X_W-1:0] x,
    logic [hmps_pkg::Y_W-1:0] y
  );
    return hmps_pkg::ADDR_W'(hmps_pkg::ADDR_W'(x) * hmps_pkg::ADDR_W'(hmps_pkg::MAP_Y)
                             + hmps_pkg::ADDR_W'(y));
  endfunction

  logic [hmps_pkg::HEIGHT_BITS-1:0] map_mem [hmps_pkg::MAP_CELLS];

  logic [hmps_pkg::TOL_W-1:0]   tol_q;
  logic [hmps_pkg::COORD_FW-1:0] cx_q, cy_q;
  logic [hmps_pkg::LEN_FW-1:0]  lx_q, ly_q;
  logic [hmps_pkg::BOX_Z_W-1:0] lz_q;
  hmps_pkg::coord_t             maxx_q, maxy_q;
  logic [3:0]                   en_q;

  hmps_pkg::coord_t             maxx_d, maxy_d;
  logic [3:0]                   en_d;

  logic [hmps_pkg::HEIGHT_BITS-1:0] rd_out_q, rd_in_q;
  logic                             rd_vld_q;

  logic [hmps_pkg::SUM_W-1:0]   acc_sum_q;
  logic [hmps_pkg::CNT_W-1:0]   acc_flush_q, acc_high_q;

  logic                         out_vld_q;
  logic [hmps_pkg::SUM_W-1:0]   out_sum_q;
  logic [hmps_pkg::CNT_W-1:0]   out_flush_q, out_high_q;

  hmps_pkg::coord_t             k, ox, oy, ix, iy;
  logic [hmps_pkg::ADDR_W-1:0]  out_addr, in_addr;

  logic                         we;
  logic [hmps_pkg::ADDR_W-1:0]  waddr;
  logic [hmps_pkg::HEIGHT_BITS-1:0] wdata;
  logic                         wr_inside;

  diff_t                        diff;
  logic [hmps_pkg::MIS_W-1:0]   mis;
  logic [hmps_pkg::SUM_W:0]     sum_ext;
  logic                         is_high;

  // Box extents and side enables for a new score.
  always_comb begin
    maxx_d  = hmps_pkg::coord_t'(item_i.coord_x) + hmps_pkg::coord_t'(item_i.box_x_len)
              - hmps_pkg::coord_t'(1);
    maxy_d  = hmps_pkg::coord_t'(item_i.coord_y) + hmps_pkg::coord_t'(item_i.box_y_len)
              - hmps_pkg::coord_t'(1);
    en_d[hmps_pkg::SIDE_LOW_X]  = hmps_pkg::coord_t'(item_i.coord_x)
                                  > hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN);
    en_d[hmps_pkg::SIDE_LOW_Y]  = hmps_pkg::coord_t'(item_i.coord_y)
                                  > hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN);
    en_d[hmps_pkg::SIDE_HIGH_X] = (maxx_d + hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN))
                                  < hmps_pkg::coord_t'(hmps_pkg::MAP_X - 1);
    en_d[hmps_pkg::SIDE_HIGH_Y] = (maxy_d + hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN))
                                  < hmps_pkg::coord_t'(hmps_pkg::MAP_Y - 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cx_q   <= item_i.coord_x;
      cy_q   <= item_i.coord_y;
      lx_q   <= item_i.box_x_len;
      ly_q   <= item_i.box_y_len;
      lz_q   <= item_i.box_z_len;
      maxx_q <= maxx_d;
      maxy_q <= maxy_d;
      en_q   <= en_d;
    end
  end

  assign sts_o.cur_len  = en_q[cmd_i.side] ? (cmd_i.side[0] ? lx_q : ly_q) : '0;
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  // Outside and inner cell of the current side position.
  always_comb begin
    k  = (cmd_i.side[0] ? hmps_pkg::coord_t'(cx_q) : hmps_pkg::coord_t'(cy_q))
         + hmps_pkg::coord_t'(cmd_i.idx);
    ox = k;
    oy = k;
    ix = k;
    iy = k;
    case (cmd_i.side)
      hmps_pkg::SIDE_LOW_X: begin
        ox = hmps_pkg::coord_t'(cx_q) - hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN + 1);
        ix = hmps_pkg::coord_t'(cx_q) + hmps_pkg::coord_t'(1);
      end
      hmps_pkg::SIDE_LOW_Y: begin
        oy = hmps_pkg::coord_t'(cy_q) - hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN + 1);
        iy = hmps_pkg::coord_t'(cy_q) + hmps_pkg::coord_t'(1);
      end
      hmps_pkg::SIDE_HIGH_X: begin
        ox = maxx_q + hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN + 1);
        ix = maxx_q - hmps_pkg::coord_t'(1);
      end
      hmps_pkg::SIDE_HIGH_Y: begin
        oy = maxy_q + hmps_pkg::coord_t'(hmps_pkg::SIDE_MARGIN + 1);
        iy = maxy_q - hmps_pkg::coord_t'(1);
      end
      default: begin
        ox = k;
      end
    endcase
    out_addr = cell_addr(clamp_x(ox), clamp_y(oy));
    in_addr  = cell_addr(clamp_x(ix), clamp_y(iy));
  end

  always_comb begin
    wr_inside = (int'(item_i.coord_x) < hmps_pkg::MAP_X)
                && (int'(item_i.coord_y) < hmps_pkg::MAP_Y);
    we        = cmd_i.clr_we || (cmd_i.write && wr_inside);
    waddr     = cmd_i.clr_we ? cmd_i.clr_addr
                : cell_addr(hmps_pkg::X_W'(item_i.coord_x), hmps_pkg::Y_W'(item_i.coord_y));
    wdata     = cmd_i.clr_we ? '0 : hmps_pkg::HEIGHT_BITS'(item_i.cell_height);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      map_mem[waddr] <= wdata;
    end
    rd_out_q <= map_mem[out_addr];
    rd_in_q  <= map_mem[in_addr];
  end

  always_comb begin
    diff    = diff_t'(rd_out_q) - diff_t'(rd_in_q) - diff_t'(lz_q);
    mis     = (diff < 0) ? hmps_pkg::MIS_W'(-diff) : hmps_pkg::MIS_W'(diff);
    sum_ext = {1'b0, acc_sum_q} + (hmps_pkg::SUM_W + 1)'(mis);
    is_high = mis > hmps_pkg::MIS_W'(tol_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_sum_q   <= '0;
      acc_flush_q <= '0;
      acc_high_q  <= '0;
    end else if (rd_vld_q) begin
      acc_sum_q <= sum_ext[hmps_pkg::SUM_W] ? hmps_pkg::SUM_MAX
                                            : sum_ext[hmps_pkg::SUM_W-1:0];
      if (is_high) begin
        if (acc_high_q != hmps_pkg::COUNT_MAX) begin
          acc_high_q <= acc_high_q + hmps_pkg::CNT_W'(1);
        end
      end else begin
        if (acc_flush_q != hmps_pkg::COUNT_MAX) begin
          acc_flush_q <= acc_flush_q + hmps_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sum_q   <= acc_sum_q;
      out_flush_q <= acc_flush_q;
      out_high_q  <= acc_high_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q     <= hmps_pkg::TOL_RESET;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_sum_o   = out_sum_q;
  assign out_flush_o = out_flush_q;
  assign out_high_o  = out_high_q;

endmodule

`default_nettype wire

/* src/heightmap_placement_scorer.sv */
// ----------------------------------------------------------------------------
// Height map placement scorer
// Keeps a bin floor height map and scores box placements against it.
//
// Input transactions arrive on s_axis. tuser selects the kind: 0 writes one
// height cell and gives no result, 1 scores a box placement at a corner.
// Results leave on m_axis, one per score transaction, in input order. The
// tolerance register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
// A cell write is made in the cycle that accepts it. A score runs through the
// accepting cycle, one cell pair read per cycle from the two read ports of the
// height map memory along each enabled side and none along a disabled one, a
// step past each side and the load of the result register. The longest score
// walks two sides of 63 cells and one of 26.
// After reset the map is swept to zero heights, one cell per cycle, over all
// 1024 cells; s_axis_tready stays low meanwhile.
// A finished result sits in the output register; the block accepts the next
// transaction while it waits, and a later score holds its result until the
// receiver takes the previous one.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_placement_scorer (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // coord_x[4:0], coord_y[9:5], cell_height[17:10], box_x_len[23:18],
  // box_y_len[29:24], box_z_len[37:30], zero fill [39:38]
  input  wire logic [hmps_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // mode[0]
  input  wire logic [0:0]                           s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // mismatch_sum[16:0], flush_count[24:17], high_count[32:25], zero fill [39:33]
  output logic [hmps_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [hmps_pkg::TOL_W-1:0]           cfg_data_i
);

  hmps_pkg::item_t             item;
  hmps_pkg::cmd_t              cmd;
  hmps_pkg::sts_t              sts;
  logic [hmps_pkg::SUM_W-1:0]  res_sum;
  logic [hmps_pkg::CNT_W-1:0]  res_flush, res_high;

  assign item.coord_x     = s_axis_tdata[4:0];
  assign item.coord_y     = s_axis_tdata[9:5];
  assign item.cell_height = s_axis_tdata[17:10];
  assign item.box_x_len   = s_axis_tdata[23:18];
  assign item.box_y_len   = s_axis_tdata[29:24];
  assign item.box_z_len   = s_axis_tdata[37:30];

  assign cfg_ready_o = 1'b1;

  hmps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hmps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_sum_o   (res_sum),
    .out_flush_o (res_flush),
    .out_high_o  (res_high)
  );

  assign m_axis_tdata = {
    (hmps_pkg::OUT_DATA_W - hmps_pkg::SUM_W - 2 * hmps_pkg::CNT_W)'(0),
    res_high,
    res_flush,
    res_sum
  };

endmodule

`default_nettype wire
